FILE: design/ses_pkg.sv
// ----------------------------------------------------------------------------
// Segmented edge softmax package
// Shared types, constants and the exponential table function.
// ----------------------------------------------------------------------------
package ses_pkg;

  localparam int unsigned Log2eQ15 = 47274;
  localparam int unsigned TFrac    = 23;

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_EXP_RD,
    ST_EXP,
    ST_DIV_RD,
    ST_DIV,
    ST_OUT,
    ST_CLEAR
  } state_t;

  typedef logic [29:0] q30_t;

  function automatic q30_t pow2_neg(input int unsigned k);
    q30_t r;
    r = 30'd0;
    case (k % 12)
      0:  r = 30'd759250125;
      1:  r = 30'd902905651;
      2:  r = 30'd984625594;
      3:  r = 30'd1028218693;
      4:  r = 30'd1050733751;
      5:  r = 30'd1062175491;
      6:  r = 30'd1067942999;
      7:  r = 30'd1070838486;
      8:  r = 30'd1072289172;
      9:  r = 30'd1073015252;
      10: r = 30'd1073378477;
      default: r = 30'd1073560135;
    endcase
    return r;
  endfunction

  // 2^(-q / 2^bits) in Q1.15, built from per-bit Q0.30 factors.
  function automatic logic [15:0] exp_rom(input int unsigned q, input int unsigned bits);
    logic [63:0] acc;
    acc = 64'd1 << 30;
    for (int unsigned j = 0; j < 12; j++) begin
      if (j < bits && ((q >> j) & 1) != 0) begin
        acc = (acc * 64'(pow2_neg(bits - j - 1)) + (64'd1 << 29)) >> 30;
      end
    end
    return 16'((acc + (64'd1 << 14)) >> 15);
  endfunction

endpackage

FILE: design/segmented_edge_softmax.sv
// ----------------------------------------------------------------------------
// Segmented edge softmax
// Buffers one vertex segment and emits per-feature softmax shares.
// ----------------------------------------------------------------------------
// Items are taken one per cycle while a segment loads. On the item marked
// segment_end, the block stops taking items and walks its buffer twice: an
// exponential pass (per element: memory read, then one shared multiplier
// and table lookup) and an output pass that runs one shared restoring
// divider per element, then holds the result until it is taken. After the
// output pass, a clear state resets the per-feature maximum and sum
// registers. Items beyond MAX_ELEMENTS are dropped and set the overflow
// flag carried on all results of the segment. A configuration write
// discards the segment.
module segmented_edge_softmax #(
  parameter int MAX_ELEMENTS   = 64,
  parameter int MAX_FEATURES   = 8,
  parameter int EXP_TABLE_BITS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [3:0]  cfg_feature_count,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic signed [15:0] in_edge_value,
  input  logic        in_segment_end,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_probability,
  output logic        out_run_last,
  output logic        out_overflowed
);
  import ses_pkg::*;

  localparam int AW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int CW = $clog2(MAX_ELEMENTS + 1);
  localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
  localparam int RomSize = 1 << EXP_TABLE_BITS;

  logic [3:0] fcount_r;
  logic [FW:0] nf;
  always_comb begin
    if (fcount_r == 4'd0) nf = (FW+1)'(1);
    else if (32'(fcount_r) > MAX_FEATURES) nf = (FW+1)'(MAX_FEATURES);
    else nf = (FW+1)'(fcount_r);
  end

  state_t state_r, state_nxt;
  logic [CW-1:0] count_r;
  logic [AW-1:0] idx_r;
  logic [FW-1:0] fpos_r, fidx_r;
  logic          ovf_r;
  logic signed [15:0] fmax_r [MAX_FEATURES];
  logic [23:0]        fsum_r [MAX_FEATURES];
  logic [15:0] vmem [MAX_ELEMENTS];
  logic [15:0] emem [MAX_ELEMENTS];
  logic [15:0] vrd_r, erd_r;
  logic [4:0]  dcnt_r;
  logic [23:0] rem_r;
  logic [16:0] quo_r;
  logic [15:0] prob_r;

  logic load_go, last_idx;
  assign in_ready = (state_r == ST_LOAD);
  assign load_go  = in_valid && in_ready && !cfg_we;
  assign last_idx = (CW'(idx_r) + CW'(1) == count_r);
  assign out_valid = (state_r == ST_OUT);
  assign out_probability = prob_r;
  assign out_run_last = last_idx;
  assign out_overflowed = ovf_r;

  // Constant table of 2^(-q / 2^EXP_TABLE_BITS) in Q1.15.
  logic [15:0] rom_tbl [RomSize];
  for (genvar g = 0; g < RomSize; g++) begin : g_rom
    assign rom_tbl[g] = exp_rom(g, EXP_TABLE_BITS);
  end

  // Exponential of (value - max).
  logic [16:0] diff;
  logic [33:0] tprod;
  logic [EXP_TABLE_BITS-1:0] rom_q;
  logic [15:0] e_val;
  logic [10:0] n_sh;
  always_comb begin
    diff  = 17'($signed({fmax_r[fidx_r][15], fmax_r[fidx_r]}) -
                $signed({vrd_r[15], vrd_r}));
    tprod = 34'(diff) * 34'(Log2eQ15);
    n_sh  = tprod[33:TFrac];
    rom_q = tprod[TFrac-1 -: EXP_TABLE_BITS];
    e_val = (n_sh >= 11'd16) ? 16'd0 : (rom_tbl[rom_q] >> n_sh[3:0]);
  end

  // Next feature index.
  logic [FW-1:0] fidx_inc, fpos_inc;
  assign fidx_inc = ((FW+1)'(fidx_r) + (FW+1)'(1) >= nf) ? '0 : FW'(fidx_r + FW'(1));
  assign fpos_inc = ((FW+1)'(fpos_r) + (FW+1)'(1) >= nf) ? '0 : FW'(fpos_r + FW'(1));

  // Divider trial subtract. The dividend is e*65536; the first step starts
  // from e shifted right by one and brings in its low bit, later steps bring
  // in zeros, so 17 steps give the whole quotient.
  logic [24:0] trial;
  logic [23:0] dsum;
  logic [23:0] rem_cur;
  logic        din_bit;
  assign dsum    = fsum_r[fidx_r];
  assign rem_cur = (dcnt_r == 5'd0) ? {9'd0, erd_r[15:1]} : rem_r;
  assign din_bit = (dcnt_r == 5'd0) ? erd_r[0] : 1'b0;
  assign trial   = {rem_cur, din_bit} - {1'b0, dsum};

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_LOAD:   if (load_go && in_segment_end) state_nxt = ST_EXP_RD;
      ST_EXP_RD: state_nxt = ST_EXP;
      ST_EXP:    state_nxt = last_idx ? ST_DIV_RD : ST_EXP_RD;
      ST_DIV_RD: state_nxt = ST_DIV;
      ST_DIV:    if (dcnt_r == 5'd16) state_nxt = ST_OUT;
      ST_OUT:    if (out_ready) state_nxt = last_idx ? ST_CLEAR : ST_DIV_RD;
      ST_CLEAR:  state_nxt = ST_LOAD;
      default:   state_nxt = ST_LOAD;
    endcase
    if (cfg_we) state_nxt = ST_CLEAR;
  end

  always_ff @(posedge clk) begin
    if (load_go && 32'(count_r) < MAX_ELEMENTS) vmem[AW'(count_r)] <= in_edge_value;
    if (state_r == ST_EXP) emem[idx_r] <= e_val;
    vrd_r <= vmem[idx_r];
    erd_r <= emem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      fcount_r <= 4'd1;
      count_r <= '0; idx_r <= '0; fpos_r <= '0; fidx_r <= '0; ovf_r <= 1'b0;
      dcnt_r <= '0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_LOAD: if (load_go) begin
          if (32'(count_r) < MAX_ELEMENTS) begin
            if (in_edge_value > fmax_r[fpos_r]) fmax_r[fpos_r] <= in_edge_value;
            count_r <= count_r + CW'(1);
            fpos_r <= fpos_inc;
          end else ovf_r <= 1'b1;
          if (in_segment_end) begin
            idx_r <= '0; fidx_r <= '0;
          end
        end
        ST_EXP: begin
          fsum_r[fidx_r] <= fsum_r[fidx_r] + 24'(e_val);
          idx_r <= last_idx ? '0 : idx_r + AW'(1);
          fidx_r <= last_idx ? '0 : fidx_inc;
        end
        ST_DIV_RD: begin dcnt_r <= '0; rem_r <= '0; quo_r <= '0; end
        ST_DIV: begin
          // Bit-serial long division of e*65536 by the feature sum.
          if (!trial[24]) begin rem_r <= trial[23:0]; quo_r <= {quo_r[15:0], 1'b1}; end
          else begin rem_r <= {rem_cur[22:0], din_bit}; quo_r <= {quo_r[15:0], 1'b0}; end
          dcnt_r <= dcnt_r + 5'd1;
          if (dcnt_r == 5'd16) begin
            prob_r <= (dsum == 24'd0 || quo_r[16] || quo_r[15]) ? 16'hFFFF :
                      {quo_r[14:0], !trial[24]};
          end
        end
        ST_OUT: if (out_ready) begin
          idx_r <= idx_r + AW'(1);
          fidx_r <= fidx_inc;
        end
        ST_CLEAR: begin
          for (int f = 0; f < MAX_FEATURES; f++) begin
            fmax_r[f] <= 16'sh8000; fsum_r[f] <= '0;
          end
          count_r <= '0; fpos_r <= '0; ovf_r <= 1'b0; idx_r <= '0; fidx_r <= '0;
        end
        default: ;
      endcase
      if (cfg_we) begin
        fcount_r <= cfg_feature_count;
      end
    end
  end
endmodule

FILE: design/ses_checker.sv
// ----------------------------------------------------------------------------
// Segmented edge softmax port checker
// Watches handshake behavior on the top level ports.
// ----------------------------------------------------------------------------
module ses_checker (
  input logic clk,
  input logic rst_n,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [15:0] out_probability
);
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid)) else $error("input and output both open");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_probability))
    else $error("result changed while stalled");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("ready during output");
endmodule

bind segmented_edge_softmax ses_checker u_ses_checker (
  .clk(clk), .rst_n(rst_n), .in_ready(in_ready), .out_valid(out_valid),
  .out_ready(out_ready), .out_probability(out_probability));
